// ----- design/udt_pkg.sv -----
// Shared types and pipeline constants for the Unix time to date text converter.
`timescale 1ns / 1ps

package udt_pkg;

   // Register stages in the calendar path, from day count to year halves
   localparam int CIVIL_STAGES = 9;

   // Register stages in the time-of-day split before alignment padding
   localparam int TOD_STAGES = 4;

   // Hour, minute and second of the local day, as binary values
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   // Calendar date, year split into centuries and years of the century
   typedef struct packed {
      logic [5:0] year_hi;
      logic [6:0] year_lo;
      logic [3:0] month;
      logic [4:0] day;
   } date_type;

endpackage

// ----- design/unix_time_to_date_text.sv -----
// Top level: Unix timestamp to local date and time as packed ASCII digits.
`timescale 1ns / 1ps

// Converts a 32-bit Unix timestamp plus a signed time-zone offset (reset
// +28800 s) into year, month, day, hour, minute and second, each given as
// ASCII decimal digits with the most significant character in the top 6 bits.
// The pipeline takes one request per clock while no result waits at the output
// and returns each result after four stages for the offset add and day split,
// nine for the calendar math and one for the digit conversion, which is also the
// output register. When a result waits at the output, every stage holds and
// req_ready drops in the same cycle. The offset register may be written at
// any time the pipeline holds no request.

module unix_time_to_date_text (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [16:0] csr_utc_offset_seconds,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_unix_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [29:0]        rsp_year_text,
   output logic [13:0]        rsp_month_text,
   output logic [13:0]        rsp_day_text,
   output logic [13:0]        rsp_hour_text,
   output logic [13:0]        rsp_minute_text,
   output logic [13:0]        rsp_second_text
);

   localparam logic signed [16:0] OFFSET_RESET = 17'sd28800;

   // Two ASCII digits of a value below 100, tens in the top byte
   function automatic logic [15:0] two_ascii(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] ones;
      tens = '0;
      for (int k = 1; k < 10; k++) begin
         if (v >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      ones = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
      return {4'h3, tens, 4'h3, ones[3:0]};
   endfunction

   logic signed [16:0] offset_ff;
   logic               en;
   logic               split_valid;
   logic [19:0]        days;
   logic [16:0]        sod;
   logic               civil_valid;
   udt_pkg::date_type  date;
   udt_pkg::tod_type   tod;
   logic [15:0]        hi_text;
   logic [15:0]        lo_text;
   logic               rsp_valid_ff;
   logic [29:0]        year_text_ff;
   logic [13:0]        month_text_ff;
   logic [13:0]        day_text_ff;
   logic [13:0]        hour_text_ff;
   logic [13:0]        minute_text_ff;
   logic [13:0]        second_text_ff;

   // Hold the whole pipeline while a result waits at the output
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // Offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_valid) begin
         offset_ff <= csr_utc_offset_seconds;
      end
   end

   udt_split u_split (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .unix_seconds (req_unix_seconds),
      .offset       (offset_ff),
      .out_valid    (split_valid),
      .days         (days),
      .sod          (sod)
   );

   udt_tod u_tod (
      .clock (clock),
      .en    (en),
      .sod   (sod),
      .tod   (tod)
   );

   udt_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (split_valid),
      .days      (days),
      .out_valid (civil_valid),
      .date      (date)
   );

   // Convert to digits into the output register
   assign hi_text = two_ascii(7'(date.year_hi));
   assign lo_text = two_ascii(date.year_lo);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= civil_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         year_text_ff   <= {hi_text[13:0], lo_text};
         month_text_ff  <= 14'(two_ascii(7'(date.month)));
         day_text_ff    <= 14'(two_ascii(7'(date.day)));
         hour_text_ff   <= 14'(two_ascii(7'(tod.hour)));
         minute_text_ff <= 14'(two_ascii(7'(tod.minute)));
         second_text_ff <= 14'(two_ascii(7'(tod.second)));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_year_text   = year_text_ff;
   assign rsp_month_text  = month_text_ff;
   assign rsp_day_text    = day_text_ff;
   assign rsp_hour_text   = hour_text_ff;
   assign rsp_minute_text = minute_text_ff;
   assign rsp_second_text = second_text_ff;

endmodule

// ----- design/udt_split.sv -----
// Offset add and split of local time into day count and seconds of the day.
`timescale 1ns / 1ps

module udt_split (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        unix_seconds,
   input  logic signed [16:0] offset,
   output logic               out_valid,
   output logic [19:0]        days,
   output logic [16:0]        sod
);

   // 86400 = 128 * 675; divide the upper 25 bits by 675 through a reciprocal
   localparam logic [25:0] DAY_RECIP     = 26'd50903317;
   localparam logic [24:0] DAY_DIVISOR   = 25'd675;
   localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;

   logic [3:0]  valid_ff;
   logic [31:0] t_ff;
   logic [31:0] t_in;
   logic [50:0] prod_ff;
   logic [50:0] prod_in;
   logic [24:0] x_ff;
   logic [6:0]  lo2_ff;
   logic [15:0] q_ff;
   logic [15:0] q_in;
   logic [9:0]  rem_ff;
   logic [9:0]  rem_in;
   logic [6:0]  lo3_ff;
   logic [19:0] days_ff;
   logic [19:0] days_in;
   logic [16:0] sod_ff;
   logic [16:0] sod_in;

   // Add the sign-extended offset, wrapping at 32 bits
   assign t_in = unix_seconds + 32'(offset);

   // Multiply by the reciprocal of 675
   assign prod_in = 51'(t_ff[31:7]) * 51'(DAY_RECIP);

   // Take the quotient and the remainder in units of 128 seconds
   assign q_in   = prod_ff[50:35];
   assign rem_in = 10'(x_ff - 25'(q_in) * DAY_DIVISOR);

   // Rebase the day count to 0000-03-01 and rebuild seconds of the day
   assign days_in = 20'(q_ff) + DAYS_TO_EPOCH;
   assign sod_in  = {rem_ff, lo3_ff};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         prod_ff <= prod_in;
         x_ff    <= t_ff[31:7];
         lo2_ff  <= t_ff[6:0];
         q_ff    <= q_in;
         rem_ff  <= rem_in;
         lo3_ff  <= lo2_ff;
         days_ff <= days_in;
         sod_ff  <= sod_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign days      = days_ff;
   assign sod       = sod_ff;

endmodule

// ----- design/udt_tod.sv -----
// Split of seconds of the day into hour, minute and second, padded to the date path.
`timescale 1ns / 1ps

module udt_tod (
   input  logic                  clock,
   input  logic                  en,
   input  logic [16:0]           sod,
   output udt_pkg::tod_type      tod
);

   localparam int TOD_PAD = udt_pkg::CIVIL_STAGES - udt_pkg::TOD_STAGES;

   // 3600 = 16 * 225 and 60 = 4 * 15, both through reciprocals
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   logic [26:0]      hprod_ff;
   logic [16:0]      sod_ff;
   logic [4:0]       hour_ff;
   logic [4:0]       hour_in;
   logic [11:0]      rem_ff;
   logic [11:0]      rem_in;
   logic [20:0]      mprod_ff;
   logic [11:0]      rem2_ff;
   logic [4:0]       hour2_ff;
   logic [5:0]       minute_in;
   logic [5:0]       second_in;
   udt_pkg::tod_type tod_ff;
   udt_pkg::tod_type pad_ff [TOD_PAD];

   // Hour from the registered product, then the seconds left in the hour
   assign hour_in = 5'(hprod_ff[26:21]);
   assign rem_in  = 12'(sod_ff - 17'(hour_in) * 17'd3600);

   // Minute from the registered product, then the seconds left
   assign minute_in = 6'(mprod_ff[20:14]);
   assign second_in = 6'(rem2_ff - 12'(minute_in) * 12'd60);

   // Advance the stages and the alignment line
   always_ff @(posedge clock) begin
      if (en) begin
         hprod_ff      <= 27'(sod[16:4]) * 27'(HOUR_RECIP);
         sod_ff        <= sod;
         hour_ff       <= hour_in;
         rem_ff        <= rem_in;
         mprod_ff      <= 21'(rem_ff[11:2]) * 21'(MIN_RECIP);
         rem2_ff       <= rem_ff;
         hour2_ff      <= hour_ff;
         tod_ff.hour   <= hour2_ff;
         tod_ff.minute <= minute_in;
         tod_ff.second <= second_in;
         pad_ff[0]     <= tod_ff;
         for (int i = 1; i < TOD_PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
   end

   assign tod = pad_ff[TOD_PAD-1];

endmodule

// ----- design/udt_civil.sv -----
// Era-based civil-from-days pipeline: day count to year, month and day.
`timescale 1ns / 1ps

module udt_civil (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [19:0]       days,
   output logic              out_valid,
   output udt_pkg::date_type date
);

   localparam logic [19:0] DAYS_PER_ERA = 20'd146097;
   localparam logic [16:0] RECIP_1460   = 17'd91930;   // (doe / 4) / 365
   localparam logic [18:0] RECIP_365    = 19'd367720;
   localparam logic [11:0] RECIP_153    = 12'd3427;
   localparam logic [12:0] RECIP_100    = 13'd5243;

   // First day of each month in the March-based year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         default: r = 9'd337;
      endcase
      return r;
   endfunction

   logic [udt_pkg::CIVIL_STAGES-1:0] valid_ff;

   // Stage 1: era and day of era
   logic [2:0]  era1_in;
   logic [2:0]  era1_ff;
   logic [17:0] doe1_ff;
   logic [17:0] doe1_in;
   // Stage 2: pieces of the leap correction
   logic [32:0] aprod2_ff;
   logic [2:0]  b2_in;
   logic [2:0]  b2_ff;
   logic        c2_ff;
   logic [17:0] doe2_ff;
   logic [2:0]  era2_ff;
   // Stage 3: corrected day count
   logic [17:0] n3_ff;
   logic [17:0] doe3_ff;
   logic [2:0]  era3_ff;
   // Stage 4: year-of-era product
   logic [36:0] yprod4_ff;
   logic [17:0] doe4_ff;
   logic [2:0]  era4_ff;
   // Stage 5: year of era and day of year
   logic [8:0]  yoe5_in;
   logic [8:0]  yoe5_ff;
   logic [1:0]  cent5;
   logic [17:0] base5;
   logic [8:0]  doy5_ff;
   logic [2:0]  era5_ff;
   // Stage 6: March-based month
   logic [10:0] v6;
   logic [22:0] mprod6;
   logic [3:0]  mp6_ff;
   logic [8:0]  doy6_ff;
   logic [8:0]  yoe6_ff;
   logic [2:0]  era6_ff;
   // Stage 7: civil month, day and year
   logic [3:0]  month7_in;
   logic [3:0]  month7_ff;
   logic [4:0]  day7_ff;
   logic [11:0] year7_ff;
   // Stage 8: century product
   logic [24:0] hprod8_ff;
   logic [11:0] year8_ff;
   logic [3:0]  month8_ff;
   logic [4:0]  day8_ff;
   // Stage 9: year halves
   logic [5:0]  hi9_in;
   udt_pkg::date_type date_ff;

   // Count the eras passed with independent compares
   always_comb begin
      era1_in = '0;
      for (int k = 1; k < 8; k++) begin
         if (days >= 20'(k * 146097)) begin
            era1_in = 3'(k);
         end
      end
   end
   assign doe1_in = 18'(days - 20'(era1_in) * DAYS_PER_ERA);

   // Count the 100-year boundaries within the era
   always_comb begin
      b2_in = '0;
      for (int k = 1; k < 5; k++) begin
         if (doe1_ff >= 18'(k * 36524)) begin
            b2_in = 3'(k);
         end
      end
   end

   // Year of era from its product; subtract the days before it
   assign yoe5_in = 9'(yprod4_ff[36:27]);
   always_comb begin
      cent5 = '0;
      for (int k = 1; k < 4; k++) begin
         if (yoe5_in >= 9'(k * 100)) begin
            cent5 = 2'(k);
         end
      end
   end
   assign base5 = 18'(yoe5_in) * 18'd365 + 18'(yoe5_in[8:2]) - 18'(cent5);

   // March-based month from (5 * doy + 2) / 153
   assign v6     = {doy5_ff, 2'b00} + 11'(doy5_ff) + 11'd2;
   assign mprod6 = 23'(v6) * 23'(RECIP_153);

   // Fold March-based month into calendar month
   assign month7_in = (mp6_ff < 4'd10) ? 4'(mp6_ff + 4'd3) : 4'(mp6_ff - 4'd9);

   assign hi9_in = 6'(hprod8_ff[24:19]);

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[udt_pkg::CIVIL_STAGES-2:0], in_valid};
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         era1_ff   <= era1_in;
         doe1_ff   <= doe1_in;

         aprod2_ff <= 33'(doe1_ff[17:2]) * 33'(RECIP_1460);
         b2_ff     <= b2_in;
         c2_ff     <= (doe1_ff == 18'd146096);
         doe2_ff   <= doe1_ff;
         era2_ff   <= era1_ff;

         n3_ff     <= 18'(doe2_ff - 18'(aprod2_ff[32:25]) + 18'(b2_ff) - 18'(c2_ff));
         doe3_ff   <= doe2_ff;
         era3_ff   <= era2_ff;

         yprod4_ff <= 37'(n3_ff) * 37'(RECIP_365);
         doe4_ff   <= doe3_ff;
         era4_ff   <= era3_ff;

         yoe5_ff   <= yoe5_in;
         doy5_ff   <= 9'(doe4_ff - base5);
         era5_ff   <= era4_ff;

         mp6_ff    <= mprod6[22:19];
         doy6_ff   <= doy5_ff;
         yoe6_ff   <= yoe5_ff;
         era6_ff   <= era5_ff;

         month7_ff <= month7_in;
         day7_ff   <= 5'(doy6_ff - month_start(mp6_ff) + 9'd1);
         year7_ff  <= 12'(yoe6_ff) + 12'(era6_ff) * 12'd400
                      + 12'(month7_in <= 4'd2);

         hprod8_ff <= 25'(year7_ff) * 25'(RECIP_100);
         year8_ff  <= year7_ff;
         month8_ff <= month7_ff;
         day8_ff   <= day7_ff;

         date_ff.year_hi <= hi9_in;
         date_ff.year_lo <= 7'(year8_ff - 12'(hi9_in) * 12'd100);
         date_ff.month   <= month8_ff;
         date_ff.day     <= day8_ff;
      end
   end

   assign out_valid = valid_ff[udt_pkg::CIVIL_STAGES-1];
   assign date      = date_ff;

endmodule
